// ===== rtl/ilb_pkg.sv =====
`default_nettype none

package ilb_pkg;

    // Radix select codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    // Type suffix codes
    localparam logic [3:0] TC_NONE = 4'd0;
    localparam logic [3:0] TC_I8   = 4'd1;
    localparam logic [3:0] TC_I16  = 4'd2;
    localparam logic [3:0] TC_I32  = 4'd3;
    localparam logic [3:0] TC_I64  = 4'd4;
    localparam logic [3:0] TC_U8   = 4'd5;
    localparam logic [3:0] TC_U16  = 4'd6;
    localparam logic [3:0] TC_U32  = 4'd7;
    localparam logic [3:0] TC_U64  = 4'd8;

    localparam int VALUE_W = 64;

    // Marks a character as no digit at all
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    typedef logic [VALUE_W-1:0] t_value;

    // Digit value of a character, DIGIT_NONE when it is not a hex digit
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= "0" && c <= "9") begin
            d = 5'(c - 8'h30);
        end else if (c >= "a" && c <= "f") begin
            d = 5'(c - 8'h57);
        end else if (c >= "A" && c <= "F") begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

    function automatic logic [4:0] base_of(input logic [1:0] sel);
        logic [4:0] b;
        case (sel)
            RADIX_HEX: b = 5'd16;
            RADIX_OCT: b = 5'd8;
            RADIX_BIN: b = 5'd2;
            default:   b = 5'd10;
        endcase
        return b;
    endfunction

    // Value above the suffix type maximum; every maximum is 2^k-1
    function automatic logic over_max(input t_value v, input logic [3:0] code);
        logic r;
        case (code)
            TC_I8:   r = |v[VALUE_W-1:7];
            TC_I16:  r = |v[VALUE_W-1:15];
            TC_I32:  r = |v[VALUE_W-1:31];
            TC_I64:  r = v[VALUE_W-1];
            TC_U8:   r = |v[VALUE_W-1:8];
            TC_U16:  r = |v[VALUE_W-1:16];
            TC_U32:  r = |v[VALUE_W-1:32];
            TC_U64:  r = 1'b0;
            TC_NONE: r = 1'b0;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/int_literal_to_binary.sv =====
// A character beat is taken into the input register and parsed from there into the parser
// state; a last character's result goes to the result register and shows on o_out_valid.
// Throughput: one character per cycle unless a last character waits on a held result;
// the single 64-bit shift-and-add of the accumulator update sets the per-character cost.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser to the
// start of a token with a zero value.
`default_nettype none

module int_literal_to_binary
    import ilb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_char_in,
    input  wire logic          i_is_last,
    input  wire logic [3:0]    i_type_code,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_value             o_value,
    output logic               o_is_float,
    output logic               o_out_of_range
);

    // Input stage
    logic       r_s1_vld;
    logic [7:0] r_char;
    logic       r_last;
    logic [3:0] r_code;

    // Parser state
    logic [1:0] r_idx,     n_idx;
    logic       r_first,   n_first;
    logic [1:0] r_radix,   n_radix;
    logic       r_prefix,  n_prefix;
    logic       r_stopped, n_stopped;
    logic       r_float,   n_float;
    t_value     r_acc,     n_acc;

    // Output stage
    logic       r_out_vld;
    t_value     r_value;
    logic       r_is_float;
    logic       r_oor;

    logic       out_free;
    logic       fire;
    logic       took;
    logic [1:0] pre_radix;
    logic [4:0] digit;
    logic       dig_ok;
    t_value     acc_mul;
    logic       res_float;

    assign out_free   = !r_out_vld || i_out_ready;
    assign fire       = r_s1_vld && (!r_last || out_free);
    assign o_in_ready = !r_s1_vld || fire;

    // Character classification and next parser state
    always_comb begin
        n_float = r_float || r_char == "." || r_char == "e" || r_char == "E";
        n_first = (r_idx == 2'd0) ? (r_char == "0") : r_first;

        took      = 1'b0;
        pre_radix = RADIX_DEC;
        if (r_idx == 2'd1 && r_first) begin
            if (r_char == "x" || r_char == "X") begin
                took      = 1'b1;
                pre_radix = RADIX_HEX;
            end else if (r_char == "o" || r_char == "O") begin
                took      = 1'b1;
                pre_radix = RADIX_OCT;
            end else if (r_char == "b" || r_char == "B") begin
                took      = 1'b1;
                pre_radix = RADIX_BIN;
            end
        end
        n_radix  = took ? pre_radix : r_radix;
        n_prefix = r_prefix || took;

        digit  = digit_of(r_char);
        dig_ok = digit < base_of(r_radix);

        case (r_radix)
            RADIX_HEX: acc_mul = r_acc << 4;
            RADIX_OCT: acc_mul = r_acc << 3;
            RADIX_BIN: acc_mul = r_acc << 1;
            default:   acc_mul = (r_acc << 3) + (r_acc << 1);
        endcase

        if (took) begin
            n_acc = '0;
        end else if (!r_stopped && dig_ok) begin
            n_acc = acc_mul + t_value'(digit);
        end else begin
            n_acc = r_acc;
        end
        n_stopped = r_stopped || (!took && !dig_ok);

        n_idx     = (r_idx == 2'd2) ? r_idx : r_idx + 2'd1;
        res_float = n_float && !n_prefix;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
            r_last <= i_is_last;
            r_code <= i_type_code;
        end
    end

    // Parser state, back to the start after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_last)) begin
            r_idx     <= 2'd0;
            r_first   <= 1'b0;
            r_radix   <= RADIX_DEC;
            r_prefix  <= 1'b0;
            r_stopped <= 1'b0;
            r_float   <= 1'b0;
            r_acc     <= '0;
        end else if (fire) begin
            r_idx     <= n_idx;
            r_first   <= n_first;
            r_radix   <= n_radix;
            r_prefix  <= n_prefix;
            r_stopped <= n_stopped;
            r_float   <= n_float;
            r_acc     <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && r_last) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (fire && r_last) begin
            r_value    <= n_acc;
            r_is_float <= res_float;
            r_oor      <= !res_float && over_max(n_acc, r_code);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_value        = r_value;
    assign o_is_float     = r_is_float;
    assign o_out_of_range = r_oor;

    // Checks
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_last |=> r_idx == 2'd0 && !r_prefix && r_acc == '0)
        else $error("parser state not cleared after last beat");

    a_prefix_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix |-> r_radix != RADIX_DEC && r_idx == 2'd2)
        else $error("prefix seen without a radix");

    a_oor_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_oor |-> !r_is_float)
        else $error("out of range flagged on a float");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld)
        else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

import ilb_pkg::*;

typedef struct {
    t_value value;
    logic   is_float;
    logic   out_of_range;
} t_literal;

// Tracks the token being parsed and holds the literals still owed by the block
class literal_scoreboard;
    logic [1:0] pos;
    logic       lead_zero;
    logic [1:0] radix;
    logic       prefix_taken;
    logic       digits_done;
    logic       float_mark;
    t_value     acc;

    t_literal   pending_literals[$];
    int         errors;
    int         n_chars;
    int         n_literals;
    int         n_float;
    int         n_oor;

    function new();
        errors     = 0;
        n_chars    = 0;
        n_literals = 0;
        n_float    = 0;
        n_oor      = 0;
        clear_token();
    endfunction

    function void clear_token();
        pos          = 2'd0;
        lead_zero    = 1'b0;
        radix        = RADIX_DEC;
        prefix_taken = 1'b0;
        digits_done  = 1'b0;
        float_mark   = 1'b0;
        acc          = '0;
    endfunction

    function t_value radix_base(logic [1:0] sel);
        t_value b;
        case (sel)
            RADIX_HEX: b = 64'd16;
            RADIX_OCT: b = 64'd8;
            RADIX_BIN: b = 64'd2;
            default:   b = 64'd10;
        endcase
        return b;
    endfunction

    // Hex digit weight; 16 for anything that is no digit in any base
    function t_value char_weight(logic [7:0] c);
        t_value w;
        w = 64'd16;
        if (c >= "0" && c <= "9") w = t_value'(c) - t_value'("0");
        if (c >= "a" && c <= "f") w = t_value'(c) - t_value'("a") + 64'd10;
        if (c >= "A" && c <= "F") w = t_value'(c) - t_value'("A") + 64'd10;
        return w;
    endfunction

    function t_value type_limit(logic [3:0] code);
        t_value lim;
        case (code)
            TC_I8:   lim = 64'd127;
            TC_I16:  lim = 64'd32767;
            TC_I32:  lim = 64'd2147483647;
            TC_I64:  lim = 64'h7FFF_FFFF_FFFF_FFFF;
            TC_U8:   lim = 64'd255;
            TC_U16:  lim = 64'd65535;
            TC_U32:  lim = 64'hFFFF_FFFF;
            default: lim = '1;
        endcase
        return lim;
    endfunction

    // Accepted input beat: advance the token and queue a literal on its last character
    function void note_char(logic [7:0] c, logic last, logic [3:0] code);
        logic     took;
        t_value   base;
        t_value   w;
        t_literal lit;
        took = 1'b0;
        n_chars++;
        if (c == "." || c == "e" || c == "E") float_mark = 1'b1;

        if (pos == 2'd0) begin
            lead_zero = (c == "0");
        end else if (pos == 2'd1 && lead_zero) begin
            if (c == "x" || c == "X") begin
                radix = RADIX_HEX;
                took  = 1'b1;
            end else if (c == "o" || c == "O") begin
                radix = RADIX_OCT;
                took  = 1'b1;
            end else if (c == "b" || c == "B") begin
                radix = RADIX_BIN;
                took  = 1'b1;
            end
            if (took) begin
                prefix_taken = 1'b1;
                acc          = '0;
            end
        end

        // digits stop for good at the first one outside the base
        if (!took && !digits_done) begin
            base = radix_base(radix);
            w    = char_weight(c);
            if (w >= base) digits_done = 1'b1;
            else acc = acc * base + w;
        end
        if (pos != 2'd2) pos = pos + 2'd1;

        if (last) begin
            lit.value        = acc;
            lit.is_float     = float_mark && !prefix_taken;
            lit.out_of_range = 1'b0;
            if (!lit.is_float && code >= TC_I8 && code <= TC_U64)
                lit.out_of_range = (acc > type_limit(code));
            pending_literals.push_back(lit);
            clear_token();
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Output beat: compare with the oldest owed literal
    task check_result(t_value v, logic f, logic o);
        t_literal lit;
        if (pending_literals.size() == 0) begin
            report($sformatf("unexpected literal value=%h", v));
        end else begin
            lit = pending_literals.pop_front();
            n_literals++;
            if (lit.is_float) n_float++;
            if (lit.out_of_range) n_oor++;
            if (v !== lit.value)
                report($sformatf("value %h, predicted %h", v, lit.value));
            if (f !== lit.is_float)
                report($sformatf("is_float %b, predicted %b", f, lit.is_float));
            if (o !== lit.out_of_range)
                report($sformatf("out_of_range %b, predicted %b", o, lit.out_of_range));
        end
    endtask
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_CHARS = 270;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_char_in   = 8'd0;
    logic        i_is_last   = 1'b0;
    logic [3:0]  i_type_code = TC_NONE;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_value      o_value;
    logic        o_is_float;
    logic        o_out_of_range;

    literal_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycles = 0;
    int          noise_tokens = 0;
    logic [7:0]  tok[$];

    int_literal_to_binary u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_in      (i_char_in),
        .i_is_last      (i_is_last),
        .i_type_code    (i_type_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_value        (o_value),
        .o_is_float     (o_is_float),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_value, o_is_float, o_out_of_range);
    end

    task automatic send_beat(input logic [7:0] c, input logic last, input logic [3:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_in   <= c;
        i_is_last   <= last;
        i_type_code <= code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_char(c, last, code);
    endtask

    // Suffix code only matters on the last beat; others carry junk
    task automatic send_token(input logic [3:0] code);
        int n;
        n = tok.size();
        for (int i = 0; i < n; i++)
            send_beat(tok[i], i == n - 1, (i == n - 1) ? code : 4'($urandom_range(15)));
        tok.delete();
    endtask

    task automatic add_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'h20;
            tok.push_back(c);
        end
    endtask

    task automatic add_digits(input int n);
        for (int i = 0; i < n; i++) tok.push_back(8'h30 + 8'($urandom_range(9)));
    endtask

    function automatic logic [3:0] pick_code();
        logic [3:0] code;
        if ($urandom_range(2) == 0) code = 4'($urandom_range(15));
        else code = 4'($urandom_range(TC_U64, TC_I8));
        return code;
    endfunction

    // One random token, mostly well formed
    task automatic random_token();
        int         kind;
        t_value     v;
        logic [3:0] code;
        kind = $urandom_range(99);
        v    = {$urandom, $urandom};
        code = pick_code();
        if (kind < 20) begin
            // decimal right at a suffix limit
            code = 4'($urandom_range(TC_U64, TC_I8));
            v    = sb.type_limit(code) + t_value'($signed($urandom_range(4)) - 2);
            if ($urandom_range(3) == 0) tok.push_back("0");
            add_text($sformatf("%0d", v), 0);
            if ($urandom_range(3) == 0) code = 4'($urandom_range(15));
        end else if (kind < 35) begin
            add_text("0x", 1);
            add_text($sformatf("%0h", v >> $urandom_range(63)), 1);
            if ($urandom_range(4) == 0) add_text($sformatf("%0h", v), 1);
        end else if (kind < 45) begin
            add_text("0o", 1);
            add_text($sformatf("%0o", v >> $urandom_range(63)), 0);
        end else if (kind < 55) begin
            add_text("0b", 1);
            add_text($sformatf("%0b", v >> $urandom_range(63, 30)), 0);
        end else if (kind < 65) begin
            // float shapes, now and then behind a radix prefix
            if ($urandom_range(4) == 0) add_text("0x", 0);
            add_digits($urandom_range(4));
            case ($urandom_range(2))
                0: tok.push_back(".");
                1: tok.push_back("e");
                default: tok.push_back("E");
            endcase
            add_digits($urandom_range(4));
        end else if (kind < 75) begin
            // long decimals, from 18 to 28 digits, can wrap the value
            add_digits($urandom_range(28, 18));
        end else if (kind < 88) begin
            // broken token: one character replaced or inserted
            add_digits($urandom_range(6, 1));
            if ($urandom_range(1) == 0)
                tok[$urandom_range(tok.size() - 1)] = 8'($urandom_range(255));
            else
                tok.insert($urandom_range(tok.size()), 8'($urandom_range(255)));
        end else begin
            noise_tokens++;
            for (int i = $urandom_range(6, 1); i > 0; i--) tok.push_back(8'($urandom_range(255)));
        end
        send_token(code);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_literals.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed tokens: prefixes in both cases, floats, limits, odd suffix codes
        add_text("0XfF", 0);
        send_token(TC_U8);
        add_text("0o78", 0);
        send_token(TC_I8);
        add_text("0B1.", 0);
        send_token(TC_I32);
        add_text("1.5", 0);
        send_token(TC_I64);
        add_text("E", 0);
        send_token(4'd15);
        add_text("128", 0);
        send_token(TC_I8);
        tok.push_back(8'hFF);
        tok.push_back(8'h00);
        send_token(TC_U64);
        add_text("0", 0);
        send_token(TC_NONE);
        add_text("00x", 0);
        send_token(TC_U16);
        wait_drained();

        // Random phases: free flow, sparse input, heavy stall, mixed
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            while (sb.n_chars < 25 + (ph + 1) * PHASE_CHARS) random_token();
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        $display("Sent %0d characters, %0d literals checked (%0d float, %0d out of range)",
                 sb.n_chars, sb.n_literals, sb.n_float, sb.n_oor);
        $display("Noise tokens %0d, mismatches %0d", noise_tokens, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
